// File: rtl/core/pvm_pkg.sv
// Shared types and constants for the path vertex mask block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package pvm_pkg;

    localparam int VTX_W            = 32;
    localparam int IDX_W            = 5;
    localparam int CNT_W            = 6;
    localparam int MAX_VERTICES_DEF = 32;

    localparam logic [CNT_W-1:0] VCOUNT_RST = CNT_W'(32);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] row_index;
        logic [VTX_W-1:0] row_bits;
        logic [IDX_W-1:0] source_vertex;
        logic [IDX_W-1:0] target_vertex;
    } req_t;

    typedef struct packed {
        logic [VTX_W-1:0] forward_mask;
        logic [VTX_W-1:0] backward_mask;
        logic [VTX_W-1:0] path_mask;
        logic             path_nonempty;
        logic             bad_vertex;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic step;
    } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/pvm_chan.sv
// Valid/ready channel interface carrying one item of any payload type.
// Payload types come from pvm_pkg at the point of instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface pvm_chan #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pvm_cell.sv
// One ring cell: holds one adjacency row and one closure row in flight.
// Depends on pvm_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module pvm_cell
    import pvm_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int CIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cell_ctl_t               ctl,
    input  wire logic                    wr_en,
    input  wire logic [MAX_VERTICES-1:0] wr_row,
    input  wire logic [MAX_VERTICES-1:0] vm,
    input  wire logic [CIDX_W-1:0]       k,
    input  wire logic [MAX_VERTICES-1:0] pivot,
    input  wire logic [MAX_VERTICES-1:0] nbr,
    output logic      [MAX_VERTICES-1:0] upd,
    output logic      [MAX_VERTICES-1:0] row
);

    logic [MAX_VERTICES-1:0] adj_reg;
    logic [MAX_VERTICES-1:0] work_reg;
    logic [MAX_VERTICES-1:0] work_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg <= '0;
        end
        else if (wr_en)
        begin
            adj_reg <= wr_row;
        end
    end

    // Fold in the pivot row when this row already reaches the pivot vertex
    assign upd = work_reg | (work_reg[k] ? pivot : '0);

    always_comb
    begin
        work_next = work_reg;
        if (ctl.load)
        begin
            work_next = adj_reg & vm;
        end
        else if (ctl.step)
        begin
            work_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign row = work_reg;

endmodule

`default_nettype wire

// File: rtl/core/pvm_seq.sv
// Sequencer: accepts items, walks the pivot counter, owns the result valid flag.
// Depends on pvm_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module pvm_seq
    import pvm_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int CIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_query,
    input  wire logic              rsp_ready,
    output logic                   req_ready,
    output cell_ctl_t              ctl,
    output logic      [CIDX_W-1:0] k,
    output logic                   capture,
    output logic                   rsp_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam logic [CIDX_W-1:0] LAST = CIDX_W'(MAX_VERTICES - 1);

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CIDX_W-1:0] k_reg;
    logic [CIDX_W-1:0] k_next;
    logic              valid_reg;
    logic              valid_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ctl.load   = 1'b0;
        ctl.step   = 1'b0;
        capture    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_query)
                begin
                    ctl.load   = 1'b1;
                    k_next     = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                ctl.step = 1'b1;
                if (k_reg == LAST)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                // Hold the finished closure until the output register frees up
                capture = !valid_reg || rsp_ready;
                if (capture)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (capture)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
        end
    end

    assign k         = k_reg;
    assign rsp_valid = valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/path_vertex_mask.sv
// Top level of the path vertex mask block: ring of row cells plus sequencer.
// Depends on pvm_pkg, pvm_chan, pvm_cell and pvm_seq.
`timescale 1ns / 1ps
`default_nettype none

// Directed-graph reachability engine. The adjacency matrix lives in a ring of
// MAX_VERTICES cells, one row each, all rows cleared by reset (no clearing pass).
// A write item loads one row and gives no result; rows at or beyond
// MAX_VERTICES are dropped. A query item loads the live rows into the ring,
// then runs one pivot step per vertex while the rows rotate one cell per
// cycle, building the full transitive closure; the source row and the target
// column are then picked into the result register once that register is free.
// The next item is taken only after the query's result has been captured.
// Write items are taken only between queries; a finished result may wait in the
// output register while the next item is accepted. vertex_count is written
// through the cfg channel only while the block is idle: the user must keep to
// this, as the block itself does not enforce it. It is clamped to MAX_VERTICES.

module path_vertex_mask
    import pvm_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input wire logic clk,
    input wire logic rst_n,
    pvm_chan.sink    req,
    pvm_chan.sink    cfg,
    pvm_chan.source  rsp
);

    localparam int CIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

    logic [CNT_W-1:0]        vc_reg;
    logic [IDX_W-1:0]        src_reg;
    logic [IDX_W-1:0]        tgt_reg;
    rsp_t                    rsp_reg;
    rsp_t                    rsp_next;

    cell_ctl_t               ctl;
    logic [CIDX_W-1:0]       k;
    logic                    capture;
    logic                    rsp_valid;
    logic                    req_ready;
    logic                    wr_fire;

    logic [6:0]              live;
    logic [MAX_VERTICES-1:0] vm;
    logic [MAX_VERTICES-1:0] row_w [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] upd_w [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] wr_row;
    logic [CIDX_W-1:0]       s_idx;
    logic [CIDX_W-1:0]       t_idx;
    logic [MAX_VERTICES-1:0] fwd_full;
    logic [MAX_VERTICES-1:0] bwd_full;
    logic [MAX_VERTICES-1:0] path_full;
    logic                    bad;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VCOUNT_RST;
        end
        else if (cfg.valid)
        begin
            vc_reg <= cfg.data;
        end
    end

    assign live = (7'(vc_reg) > MAXV) ? MAXV : 7'(vc_reg);

    pvm_seq #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_query (req.data.command == CMD_QUERY),
        .rsp_ready (rsp.ready),
        .req_ready (req_ready),
        .ctl       (ctl),
        .k         (k),
        .capture   (capture),
        .rsp_valid (rsp_valid)
    );

    assign req.ready = req_ready;
    assign wr_fire   = req.valid && req_ready && (req.data.command == CMD_WRITE);
    assign wr_row    = MAX_VERTICES'(req.data.row_bits);

    genvar p;
    generate
        for (p = 0; p < MAX_VERTICES; p++)
        begin : g_cell
            localparam int NXT = (p + 1) % MAX_VERTICES;

            assign vm[p] = (7'(p) < live);

            pvm_cell #(
                .MAX_VERTICES (MAX_VERTICES)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .wr_en  (wr_fire && (7'(req.data.row_index) == 7'(p))),
                .wr_row (wr_row),
                .vm     (vm),
                .k      (k),
                .pivot  (row_w[0]),
                .nbr    (upd_w[NXT]),
                .upd    (upd_w[p]),
                .row    (row_w[p])
            );

            // Drop rows of vertices outside the live count
            assign bwd_full[p] = row_w[p][t_idx] & vm[p];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            src_reg <= req.data.source_vertex;
            tgt_reg <= req.data.target_vertex;
        end
    end

    assign s_idx     = CIDX_W'(src_reg);
    assign t_idx     = CIDX_W'(tgt_reg);
    assign bad       = (7'(src_reg) >= live) || (7'(tgt_reg) >= live);
    assign fwd_full  = row_w[s_idx];
    assign path_full = fwd_full & bwd_full;

    always_comb
    begin
        rsp_next.forward_mask  = VTX_W'(fwd_full);
        rsp_next.backward_mask = VTX_W'(bwd_full);
        rsp_next.path_mask     = VTX_W'(path_full);
        rsp_next.path_nonempty = |path_full;
        rsp_next.bad_vertex    = 1'b0;
        if (bad)
        begin
            rsp_next = '0;
            rsp_next.bad_vertex = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/core/pvm_checker.sv
// Port-level checks for path_vertex_mask, attached by the bind below.
// Depends on pvm_pkg for the command codes and field widths.
`timescale 1ns / 1ps
`default_nettype none

module pvm_checker
    import pvm_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             req_command,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic [VTX_W-1:0] fwd,
    input wire logic [VTX_W-1:0] bwd,
    input wire logic [VTX_W-1:0] path,
    input wire logic             nonempty,
    input wire logic             bad
);

    // A stalled result holds its value
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(path) && $stable(bad))
        else $error("result changed while stalled");

    // A bad query reports empty masks
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && bad |-> (fwd == '0) && (bwd == '0) && (path == '0) && !nonempty)
        else $error("bad query with non-zero masks");

    // The path mask is the AND of the two reach masks
    a_path_and: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> path == (fwd & bwd))
        else $error("path mask differs from forward AND backward");

    // A query holds off the next item while the closure runs
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_command == CMD_QUERY) |=> !req_ready)
        else $error("item accepted during a running query");

endmodule

bind path_vertex_mask pvm_checker u_pvm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .req_command (req.data.command),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .fwd         (rsp.data.forward_mask),
    .bwd         (rsp.data.backward_mask),
    .path        (rsp.data.path_mask),
    .nonempty    (rsp.data.path_nonempty),
    .bad         (rsp.data.bad_vertex)
);

`default_nettype wire

// File: dv/tb_path_vertex_mask.sv
// Testbench for path_vertex_mask: random graph edits and path queries, checked
// against a reachability predictor. Depends on pvm_pkg, pvm_chan and the block RTL.
`timescale 1ns / 1ps

module tb_path_vertex_mask;
    import pvm_pkg::*;

    localparam int SETTLE_CYCLES = 40;   // covers one full query walk plus margin

    logic clk;
    logic rst_n;
    int   errors;
    int   idle_pct;
    int   stall_pct;

    // predictor state
    logic [VTX_W-1:0] adj_rows [MAX_VERTICES_DEF];
    logic [CNT_W-1:0] vcount;
    rsp_t             expected_paths [$];

    pvm_chan #(.T(req_t))             req_if ();
    pvm_chan #(.T(logic [CNT_W-1:0])) cfg_if ();
    pvm_chan #(.T(rsp_t))             rsp_if ();

    path_vertex_mask u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .cfg   (cfg_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int live_vertices();
        return (vcount > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(vcount);
    endfunction

    function automatic rsp_t predict_paths(logic [IDX_W-1:0] s, logic [IDX_W-1:0] t);
        int               n;
        logic [VTX_W-1:0] live;
        logic [VTX_W-1:0] fwd;
        logic [VTX_W-1:0] bwd;
        logic [VTX_W-1:0] grown;
        rsp_t             r;
        n = live_vertices();
        r = '0;
        if (s >= n || t >= n)
        begin
            r.bad_vertex = 1'b1;
            return r;
        end
        live = (n >= VTX_W) ? '1 : ((32'd1 << n) - 32'd1);
        // forward closure from the source row
        fwd = adj_rows[s] & live;
        for (int rnd = 0; rnd < n; rnd++)
        begin
            grown = fwd;
            for (int i = 0; i < n; i++)
                if (fwd[i])
                    grown |= adj_rows[i] & live;
            if (grown == fwd)
                break;
            fwd = grown;
        end
        // backward closure from the target column
        bwd = '0;
        for (int i = 0; i < n; i++)
            if (adj_rows[i][t])
                bwd[i] = 1'b1;
        for (int rnd = 0; rnd < n; rnd++)
        begin
            grown = bwd;
            for (int i = 0; i < n; i++)
                if ((adj_rows[i] & bwd) != '0)
                    grown[i] = 1'b1;
            if (grown == bwd)
                break;
            bwd = grown;
        end
        r.forward_mask  = fwd & live;
        r.backward_mask = bwd & live;
        r.path_mask     = fwd & bwd & live;
        r.path_nonempty = (r.path_mask != '0);
        return r;
    endfunction

    function automatic req_t make_write(logic [IDX_W-1:0] idx, logic [VTX_W-1:0] bits);
        req_t it;
        it               = '0;
        it.command       = CMD_WRITE;
        it.row_index     = idx;
        it.row_bits      = bits;
        it.source_vertex = IDX_W'($urandom);
        it.target_vertex = IDX_W'($urandom);
        return it;
    endfunction

    function automatic req_t make_query(logic [IDX_W-1:0] s, logic [IDX_W-1:0] t);
        req_t it;
        it               = '0;
        it.command       = CMD_QUERY;
        it.row_index     = IDX_W'($urandom);
        it.row_bits      = $urandom;
        it.source_vertex = s;
        it.target_vertex = t;
        return it;
    endfunction

    // mostly live vertices, now and then any index
    function automatic logic [IDX_W-1:0] pick_vertex();
        int n;
        n = live_vertices();
        if (n == 0 || $urandom_range(9) == 0)
            return IDX_W'($urandom_range(31));
        return IDX_W'($urandom_range(n - 1));
    endfunction

    function automatic logic [VTX_W-1:0] random_row();
        int n;
        n = (live_vertices() == 0) ? 1 : live_vertices();
        case ($urandom_range(6))
            0:       return $urandom;
            1:       return $urandom & $urandom & $urandom;
            2:       return 32'd1 << $urandom_range(31);
            3:       return '0;
            4:       return '1;
            default: return (32'd1 << $urandom_range(n - 1)) | (32'd1 << $urandom_range(n - 1));
        endcase
    endfunction

    task automatic send_item(req_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = it;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (it.command == CMD_QUERY)
            expected_paths.push_back(predict_paths(it.source_vertex, it.target_vertex));
        else if (it.row_index < MAX_VERTICES_DEF)
            adj_rows[it.row_index] = it.row_bits;
        @(negedge clk);
    endtask

    // hold the sender until every query has answered and the block is quiet
    task automatic wait_idle();
        req_if.valid = 1'b0;
        while (expected_paths.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_vertex_count(logic [CNT_W-1:0] value);
        wait_idle();
        cfg_if.valid = 1'b1;
        cfg_if.data  = value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        vcount = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic check_field(string name, logic [VTX_W-1:0] exp, logic [VTX_W-1:0] act);
        if (act !== exp)
        begin
            $display("%0t: %s expected %h got %h", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t exp;
        rsp_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got = rsp_if.data;
            if (expected_paths.size() == 0)
            begin
                $display("%0t: unexpected result expected none got %h", $time, got);
                errors++;
            end
            else
            begin
                exp = expected_paths.pop_front();
                check_field("forward_mask", exp.forward_mask, got.forward_mask);
                check_field("backward_mask", exp.backward_mask, got.backward_mask);
                check_field("path_mask", exp.path_mask, got.path_mask);
                check_field("path_nonempty", 32'(exp.path_nonempty), 32'(got.path_nonempty));
                check_field("bad_vertex", 32'(exp.bad_vertex), 32'(got.bad_vertex));
            end
        end
    end

    always @(negedge clk)
    begin
        rsp_if.ready = ($urandom_range(99) >= stall_pct);
    end

    // random graph edits, rings, noise and queries for one phase
    task automatic run_random(int count);
        int               sent;
        int               n;
        int               k;
        int               j;
        int               tmp;
        int               choice;
        int               perm [MAX_VERTICES_DEF];
        logic [VTX_W-1:0] bits;
        sent = 0;
        while (sent < count)
        begin
            n = live_vertices();
            choice = $urandom_range(99);
            if (choice < 10 && n > 1)
            begin
                // ring or chain through a shuffled vertex order: deepest closures
                for (int i = 0; i < n; i++)
                    perm[i] = i;
                for (int i = n - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    tmp = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                tmp = $urandom_range(1);
                for (int i = 0; i < n; i++)
                begin
                    if (i == n - 1 && tmp == 1)
                        bits = '0;
                    else
                        bits = 32'd1 << perm[(i + 1) % n];
                    if ($urandom_range(7) == 0)
                        bits |= 32'd1 << $urandom_range(31);
                    send_item(make_write(IDX_W'(perm[i]), bits));
                    sent++;
                end
                k = $urandom_range(2, 5);
                for (int i = 0; i < k; i++)
                begin
                    send_item(make_query(pick_vertex(), pick_vertex()));
                    sent++;
                end
            end
            else if (choice < 88)
            begin
                k = $urandom_range(0, 4);
                for (int i = 0; i < k; i++)
                begin
                    send_item(make_write(pick_vertex(), random_row()));
                    sent++;
                end
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                begin
                    send_item(make_query(pick_vertex(), pick_vertex()));
                    sent++;
                end
            end
            else
            begin
                send_item(req_t'({$urandom, $urandom, $urandom}));
                sent++;
            end
        end
    endtask

    task automatic test_empty_graph();
        send_item(make_query(5'd0, 5'd0));
        send_item(make_query(5'd31, 5'd31));
    endtask

    task automatic test_full_rows();
        send_item(make_write(5'd0, '1));
        send_item(make_write(5'd31, '1));
        send_item(make_write(5'd5, '0));
        send_item(make_query(5'd0, 5'd31));
        send_item(make_query(5'd5, 5'd0));
        send_item(make_query(5'd31, 5'd5));
    endtask

    task automatic test_short_chain();
        send_item(make_write(5'd10, 32'd1 << 11));
        send_item(make_write(5'd11, 32'd1 << 12));
        send_item(make_write(5'd12, 32'd1 << 13));
        send_item(make_query(5'd10, 5'd13));
        send_item(make_query(5'd13, 5'd10));
    endtask

    task automatic test_vertex_bounds();
        // rows keep bits above the live count; queries must mask them
        set_vertex_count(CNT_W'(4));
        send_item(make_query(5'd4, 5'd0));
        send_item(make_query(5'd0, 5'd31));
        send_item(make_query(5'd0, 5'd3));
        set_vertex_count(CNT_W'(0));
        send_item(make_query(5'd0, 5'd0));
        set_vertex_count(CNT_W'(63));
        send_item(make_query(5'd31, 5'd31));
        set_vertex_count(CNT_W'(33));
        send_item(make_query(5'd0, 5'd31));
        set_vertex_count(CNT_W'(1));
        send_item(make_write(5'd0, 32'd1));
        send_item(make_query(5'd0, 5'd0));
        send_item(make_query(5'd1, 5'd0));
    endtask

    task automatic test_random_no_idle();
        idle_pct  = 0;
        stall_pct = 0;
        set_vertex_count(CNT_W'(32));
        run_random(150);
        set_vertex_count(CNT_W'(63));
        run_random(110);
    endtask

    task automatic test_random_sender_gaps();
        idle_pct  = 77;
        stall_pct = 0;
        set_vertex_count(CNT_W'(7));
        run_random(120);
        set_vertex_count(CNT_W'(33));
        run_random(80);
    endtask

    task automatic test_random_receiver_stalls();
        idle_pct  = 0;
        stall_pct = 77;
        set_vertex_count(CNT_W'(1));
        run_random(60);
        set_vertex_count(CNT_W'(12));
        run_random(120);
    endtask

    task automatic test_random_both_idle();
        idle_pct  = 32;
        stall_pct = 32;
        set_vertex_count(CNT_W'(0));
        run_random(40);
        set_vertex_count(CNT_W'(20));
        run_random(120);
        set_vertex_count(CNT_W'(31));
        run_random(110);
    endtask

    initial
    begin
        errors       = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        vcount       = VCOUNT_RST;
        for (int i = 0; i < MAX_VERTICES_DEF; i++)
            adj_rows[i] = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_graph();
        test_full_rows();
        test_short_chain();
        test_vertex_bounds();
        test_random_no_idle();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_both_idle();

        wait_idle();
        if (errors == 0 && expected_paths.size() == 0)
            $display("tb_path_vertex_mask: clean");
        else
            $display("tb_path_vertex_mask: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_path_vertex_mask: errors");
        $finish;
    end

endmodule
